FILE: hw/rtl/lspe_pkg.sv
// Shared types and constants for the LSB stego payload extractor.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package lspe_pkg;

   // Result kinds
   localparam logic [1:0] KIND_EXT  = 2'd0;
   localparam logic [1:0] KIND_PAY  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_MAGIC = 2'd1;
   localparam logic [1:0] ERR_EXT   = 2'd2;
   localparam logic [1:0] ERR_TRUNC = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_MAGIC_WORD   = 2'd0;
   localparam logic [1:0] CSR_MAGIC_LENGTH = 2'd1;
   localparam logic [1:0] CSR_HEADER_SKIP  = 2'd2;

   localparam logic [7:0] HEADER_SKIP_RESET = 8'd54;
   localparam logic [3:0] MAGIC_MAX_CHARS   = 4'd8;

   // Pair queue depth between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] image_byte;
      logic       start_of_image;
      logic       end_of_image;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] decoded_byte;
      logic [1:0] error_code;
      logic       last;
   } rsp_type;

   // Results of one input beat: first always present, second optional
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } pair_type;

   typedef struct packed {
      logic [7:0][7:0] magic_word;
      logic [3:0]      magic_length;
      logic [7:0]      header_skip;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lspe_front.sv
// Front end: takes image beats, runs the parse state, packs each beat's results.
// Depends on lspe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lspe_front #(
   parameter int unsigned MAX_EXT_LEN = 16
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  lspe_pkg::cfg_type  cfg,
   input  wire                logic req_valid,
   output logic               req_ready,
   input  lspe_pkg::req_type  req_payload,
   output logic               push_valid,
   input  wire                logic push_ready,
   output lspe_pkg::pair_type push_pair
);

   localparam int unsigned EXT_W = $clog2(MAX_EXT_LEN + 1);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_MAGIC  = 3'd1;
   localparam logic [2:0] PH_EXTLEN = 3'd2;
   localparam logic [2:0] PH_EXT    = 3'd3;
   localparam logic [2:0] PH_PLEN   = 3'd4;
   localparam logic [2:0] PH_PAY    = 3'd5;
   localparam logic [2:0] PH_IDLE   = 3'd6;

   logic [2:0]       phase_ff,  phase_in;
   logic [7:0]       skip_ff,   skip_in;
   logic [4:0]       bidx_ff,   bidx_in;
   logic [31:0]      bsh_ff,    bsh_in;
   logic [3:0]       midx_ff,   midx_in;
   logic [EXT_W-1:0] erem_ff,   erem_in;
   logic [31:0]      prem_ff,   prem_in;

   logic             accept;
   logic             consumed;
   logic             need32;
   logic             byte_done;
   logic [5:0]       bidx_inc;
   logic [31:0]      shifted;
   logic [7:0]       b;
   logic [3:0]       mlen_eff;
   logic [3:0]       midx_inc;
   logic [EXT_W-1:0] erem_dec;
   logic [31:0]      prem_dec;
   logic             have0;
   lspe_pkg::rsp_type r0, r1;
   logic             have1;

   assign accept    = req_valid && push_ready;
   assign req_ready = push_ready;
   assign mlen_eff  = (cfg.magic_length > lspe_pkg::MAGIC_MAX_CHARS) ?
                      lspe_pkg::MAGIC_MAX_CHARS : cfg.magic_length;

   always_comb begin
      // start from the live state, or a cleared one on start of image
      if (req_payload.start_of_image) begin
         phase_in = PH_HEADER;
         skip_in  = '0;
         bidx_in  = '0;
         bsh_in   = '0;
         midx_in  = '0;
         erem_in  = '0;
         prem_in  = '0;
      end else begin
         phase_in = phase_ff;
         skip_in  = skip_ff;
         bidx_in  = bidx_ff;
         bsh_in   = bsh_ff;
         midx_in  = midx_ff;
         erem_in  = erem_ff;
         prem_in  = prem_ff;
      end

      consumed  = 1'b0;
      have0     = 1'b0;
      have1     = 1'b0;
      r0        = '0;
      r1        = '0;
      need32    = 1'b0;
      byte_done = 1'b0;
      bidx_inc  = '0;
      shifted   = '0;
      b         = '0;
      midx_inc  = '0;
      erem_dec  = '0;
      prem_dec  = '0;

      if (phase_in == PH_HEADER) begin
         if (skip_in < cfg.header_skip) begin
            skip_in  = skip_in + 8'd1;
            consumed = 1'b1;
         end else begin
            phase_in = (mlen_eff != 4'd0) ? PH_MAGIC : PH_EXTLEN;
         end
      end

      if (!consumed && phase_in >= PH_MAGIC && phase_in <= PH_PAY) begin
         need32    = (phase_in == PH_EXTLEN) || (phase_in == PH_PLEN);
         shifted   = bsh_in | (32'(req_payload.image_byte[0]) << bidx_in);
         bidx_inc  = {1'b0, bidx_in} + 6'd1;
         byte_done = need32 ? (bidx_inc >= 6'd32) : (bidx_inc >= 6'd8);
         b         = shifted[7:0];
         if (!byte_done) begin
            bidx_in = bidx_inc[4:0];
            bsh_in  = shifted;
         end else begin
            bidx_in = '0;
            bsh_in  = '0;
            unique case (phase_in)
               PH_MAGIC: begin
                  if (b != cfg.magic_word[midx_in[2:0]]) begin
                     have0    = 1'b1;
                     r0       = '{lspe_pkg::KIND_ERR, 8'd0, lspe_pkg::ERR_MAGIC, 1'b1};
                     phase_in = PH_IDLE;
                  end else begin
                     midx_inc = midx_in + 4'd1;
                     midx_in  = midx_inc;
                     if (midx_inc >= mlen_eff) phase_in = PH_EXTLEN;
                  end
               end
               PH_EXTLEN: begin
                  if (shifted > 32'(MAX_EXT_LEN)) begin
                     have0    = 1'b1;
                     r0       = '{lspe_pkg::KIND_ERR, 8'd0, lspe_pkg::ERR_EXT, 1'b1};
                     phase_in = PH_IDLE;
                  end else begin
                     erem_in  = shifted[EXT_W-1:0];
                     phase_in = (shifted != 32'd0) ? PH_EXT : PH_PLEN;
                  end
               end
               PH_EXT: begin
                  have0    = 1'b1;
                  r0       = '{lspe_pkg::KIND_EXT, b, lspe_pkg::ERR_NONE, 1'b0};
                  erem_dec = (erem_in != '0) ? erem_in - EXT_W'(1) : erem_in;
                  erem_in  = erem_dec;
                  if (erem_dec == '0) phase_in = PH_PLEN;
               end
               PH_PLEN: begin
                  prem_in = shifted;
                  if (shifted == 32'd0) begin
                     have0    = 1'b1;
                     r0       = '{lspe_pkg::KIND_DONE, 8'd0, lspe_pkg::ERR_NONE, 1'b1};
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_PAY;
                  end
               end
               default: begin
                  have0    = 1'b1;
                  r0       = '{lspe_pkg::KIND_PAY, b, lspe_pkg::ERR_NONE,
                               (prem_in <= 32'd1)};
                  prem_dec = (prem_in != 32'd0) ? prem_in - 32'd1 : prem_in;
                  prem_in  = prem_dec;
                  if (prem_dec == 32'd0) phase_in = PH_IDLE;
               end
            endcase
         end
      end

      // truncated image: append after whatever this beat produced
      if (req_payload.end_of_image && phase_in != PH_IDLE) begin
         if (have0) begin
            have1 = 1'b1;
            r1    = '{lspe_pkg::KIND_ERR, 8'd0, lspe_pkg::ERR_TRUNC, 1'b1};
         end else begin
            have0 = 1'b1;
            r0    = '{lspe_pkg::KIND_ERR, 8'd0, lspe_pkg::ERR_TRUNC, 1'b1};
         end
         phase_in = PH_IDLE;
      end
   end

   assign push_valid      = accept && have0;
   assign push_pair.two   = have1;
   assign push_pair.first = r0;
   assign push_pair.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         skip_ff  <= '0;
         bidx_ff  <= '0;
         bsh_ff   <= '0;
         midx_ff  <= '0;
         erem_ff  <= '0;
         prem_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         bidx_ff  <= bidx_in;
         bsh_ff   <= bsh_in;
         midx_ff  <= midx_in;
         erem_ff  <= erem_in;
         prem_ff  <= prem_in;
      end
   end

   a_second_is_trunc: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_pair.two |->
         push_pair.second.kind == lspe_pkg::KIND_ERR &&
         push_pair.second.error_code == lspe_pkg::ERR_TRUNC)
      else $error("second result of a beat is not a truncation error");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      push_valid && (push_pair.two ? push_pair.second.last : push_pair.first.last)
         |=> phase_ff == PH_IDLE)
      else $error("parser not idle after a final result");

endmodule

`default_nettype wire

FILE: hw/rtl/lspe_queue.sv
// Short FIFO of result pairs between the front end and the output stage.
// Depends on lspe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lspe_queue (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic push,
   output logic               in_ready,
   input  lspe_pkg::pair_type in_pair,
   input  wire                logic pop,
   output logic               out_valid,
   output lspe_pkg::pair_type out_pair
);

   localparam int unsigned DEPTH = lspe_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   lspe_pkg::pair_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_pair  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a push");

endmodule

`default_nettype wire

FILE: hw/rtl/lspe_back.sv
// Output stage: unpacks result pairs into single response beats.
// Depends on lspe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lspe_back (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic q_valid,
   input  lspe_pkg::pair_type q_pair,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire                logic rsp_ready,
   output lspe_pkg::rsp_type  rsp_payload
);

   lspe_pkg::pair_type cur_ff, cur_in;
   logic               cur_valid_ff, cur_valid_in;
   logic               sel_ff, sel_in;
   logic               take;
   logic               finish;
   logic               load;

   assign take        = rsp_valid && rsp_ready;
   assign finish      = take && (sel_ff || !cur_ff.two);
   assign load        = !cur_valid_ff || finish;
   assign q_pop       = load && q_valid;
   assign rsp_valid   = cur_valid_ff;
   assign rsp_payload = sel_ff ? cur_ff.second : cur_ff.first;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      sel_in       = sel_ff;
      if (load) begin
         cur_in       = q_pair;
         cur_valid_in = q_valid;
         sel_in       = 1'b0;
      end else if (take) begin
         // advance to the second result of the pair
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         sel_ff       <= sel_in;
      end
   end

   a_sel_needs_two: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> cur_valid_ff && cur_ff.two)
      else $error("second result selected from a single-result pair");

endmodule

`default_nettype wire

FILE: hw/rtl/lsb_stego_payload_extractor.sv
// LSB stego payload extractor, top level: CSRs, front end, pair queue, output stage.
// Depends on lspe_pkg, lspe_front, lspe_queue and lspe_back.
//
// Usage:
//   req_*  carries carrier image beats (one byte each, start/end of image flags).
//   rsp_*  carries decoded beats: extension bytes, payload bytes, a done marker
//          for an empty payload, or an error (magic mismatch, extension too
//          long, truncated image). last marks the final beat of an image.
//   csr_*  writes magic_word, magic_length and header_skip; write only while
//          the block is idle. Writes take effect on the next beat.
// Timing:
//   One input beat is taken per cycle while req_ready is high. The front end
//   parses a beat in the cycle it is taken and files its results as one pair in
//   a four-entry queue; the output stage loads the pair into its own register
//   when it is free, and rsp_valid for the first result comes from that
//   register. The output stage sends one result beat per cycle while rsp_ready
//   is high, so a beat with two results (a byte plus the truncation error)
//   holds the output stage for both result beats.
// Reset: parse state goes back to header skip, magic_word and magic_length to
//   zero, header_skip to 54; queue and output stage empty.
// Stall: when rsp_ready is low the output stage holds its beat and the queue
//   fills; req_ready drops once all four pair slots are taken.
`timescale 1ns / 1ps
`default_nettype none

module lsb_stego_payload_extractor #(
   parameter int unsigned MAX_EXT_LEN = 16
) (
   input  wire               logic        clock,
   input  wire               logic        reset,
   input  wire               logic        req_valid,
   output logic              req_ready,
   input  lspe_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               logic        rsp_ready,
   output lspe_pkg::rsp_type rsp_payload,
   input  wire               logic        csr_we,
   input  wire               logic [1:0]  csr_index,
   input  wire               logic [63:0] csr_wdata
);

   lspe_pkg::cfg_type  cfg_ff, cfg_in;
   logic               push_valid;
   logic               push_ready;
   lspe_pkg::pair_type push_pair;
   logic               q_valid;
   logic               q_pop;
   lspe_pkg::pair_type q_pair;

   // Register file: index beyond the list is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lspe_pkg::CSR_MAGIC_WORD:   cfg_in.magic_word   = csr_wdata;
            lspe_pkg::CSR_MAGIC_LENGTH: cfg_in.magic_length = csr_wdata[3:0];
            lspe_pkg::CSR_HEADER_SKIP:  cfg_in.header_skip  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word   <= '0;
         cfg_ff.magic_length <= '0;
         cfg_ff.header_skip  <= lspe_pkg::HEADER_SKIP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: parse one beat per cycle while the queue has room, push its results as one pair
   lspe_front #(
      .MAX_EXT_LEN (MAX_EXT_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_pair   (push_pair)
   );

   // Decouple parsing from the response stall
   lspe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .in_ready  (push_ready),
      .in_pair   (push_pair),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_pair  (q_pair)
   );

   // Output stage: one response beat per cycle while rsp_ready is high
   lspe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pair      (q_pair),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
